[src/tdst_pkg.sv]
package tdst_pkg;

   // Table size and slot index width
   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   // Opcodes
   localparam logic [2:0] OP_REGISTER   = 3'd0;
   localparam logic [2:0] OP_UNREGISTER = 3'd1;
   localparam logic [2:0] OP_EXEC       = 3'd2;
   localparam logic [2:0] OP_DEADLINE   = 3'd3;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DISABLED  = 3'd3;
   localparam logic [2:0] ST_RESERVED  = 3'd4;

   // Arithmetic constants
   localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
   localparam logic [31:0] STREAK_LIMIT = 32'd3;
   localparam logic [31:0] PRED_RUNS    = 32'd10;
   localparam int          PRED_W_MEAN  = 7;
   localparam int          PRED_W_WORST = 3;
   localparam int          PRED_SUM_W   = 20;

   // Divide by 10 as (x * ceil(2^23/10)) >> 23, exact for x below 2^22
   localparam int PRED_RECIP  = 838861;
   localparam int PRED_SHIFT  = 23;
   localparam int PRED_PROD_W = 40;

   // Divider widths: quotient always fits 16 bits
   localparam int DIVD_W = 49;
   localparam int DIVS_W = 33;
   localparam int QUO_W  = 16;
   localparam int DCNT_W = $clog2(QUO_W + 1);

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] deadline;
      logic [15:0] worst;
      logic [15:0] best;
      logic [15:0] mean;
      logic [15:0] last;
      logic [31:0] runs;
      logic [31:0] misses;
      logic [31:0] streak;
      logic [31:0] peak;
      logic [15:0] min_slack;
      logic [15:0] slack_mean;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   localparam slot_rec_type REC_RESET = '{
      id: 16'd0, deadline: 16'd0, worst: 16'd0, best: 16'hFFFF,
      mean: 16'd0, last: 16'd0, runs: 32'd0, misses: 32'd0,
      streak: 32'd0, peak: 32'd0, min_slack: 16'hFFFF, slack_mean: 16'd0};

   typedef enum logic [2:0] {
      REC_HOLD, REC_NEW, REC_EXEC, REC_DEAD, REC_MEAN, REC_AVG
   } rec_op_type;

   typedef enum logic [1:0] {
      DIV_EXEC, DIV_SLACK
   } div_src_type;

   // Controller to datapath
   typedef struct packed {
      logic        load_req;
      logic        scan_clr;
      logic        scan_inc;
      logic        rec_cap;
      logic        slot_cap;
      rec_op_type  rec_op;
      logic        mul_en;
      logic        div_start;
      div_src_type div_src;
      logic        wr_en;
      logic        clr_valid;
      logic        rsp_load;
      logic        rsp_slot;
      logic        rsp_pred_div;
      logic [2:0]  rsp_status;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       id_zero;
      logic [2:0] opcode;
      logic       enable;
      logic       match;
      logic       scan_last;
      logic       runs_zero;
      logic       runs_gt10;
      logic       div_busy;
      logic       rsp_free;
   } dp_sts_type;

endpackage

[src/tdst_ram.sv]
module tdst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

[src/tdst_div.sv]
module tdst_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdst_pkg::DIVD_W-1:0] dividend,
   input  logic [tdst_pkg::DIVS_W-1:0] divisor,
   output logic                        busy,
   output logic [tdst_pkg::QUO_W-1:0]  quotient
);
   import tdst_pkg::*;

   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsor_ff;
   logic [QUO_W-1:0]  qsh_ff, qsh_in;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic [DIVS_W:0]   trial;
   logic              ge;

   // Restoring step: one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, qsh_ff[QUO_W-1]};
      ge     = trial >= {1'b0, dsor_ff};
      rem_in = ge ? DIVS_W'(trial - {1'b0, dsor_ff}) : trial[DIVS_W-1:0];
      qsh_in = {qsh_ff[QUO_W-2:0], ge};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DCNT_W'(QUO_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Data; high dividend bits sit below the divisor since the quotient fits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend[DIVD_W-1:QUO_W];
         qsh_ff  <= dividend[QUO_W-1:0];
         dsor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         qsh_ff <= qsh_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = qsh_ff;
endmodule

[src/tdst_dp.sv]
module tdst_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  tdst_pkg::ctl_cmd_type     cmd,
   output tdst_pkg::dp_sts_type      sts,
   input  logic [2:0]                req_opcode,
   input  logic [15:0]               req_task_id,
   input  logic [15:0]               req_deadline,
   input  logic [15:0]               req_exec_time,
   input  logic                      req_met,
   input  logic [15:0]               req_slack,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [15:0]               rsp_worst_time,
   output logic [15:0]               rsp_best_time,
   output logic [15:0]               rsp_mean_time,
   output logic [31:0]               rsp_run_count,
   output logic [31:0]               rsp_miss_count,
   output logic [31:0]               rsp_miss_streak,
   output logic [31:0]               rsp_peak_streak,
   output logic [15:0]               rsp_min_slack,
   output logic [15:0]               rsp_mean_slack,
   output logic                      rsp_predict_miss,
   output logic [15:0]               rsp_predicted_time
);
   import tdst_pkg::*;

   logic                 enable_ff;
   logic [2:0]           op_ff;
   logic [15:0]          id_ff, dl_ff, et_ff, sl_ff;
   logic                 met_ff;
   logic [SLOT_W-1:0]    scan_ff, slot_ff;
   logic [MAX_TASKS-1:0] valid_ff;
   slot_rec_type         rec_ff, rec_in, ram_rec, eff_rec;
   logic [REC_W-1:0]     ram_rdata;
   logic [47:0]          mul_ff, mul_in;
   logic [31:0]          n_ff;
   logic [DIVD_W-1:0]    dvd;
   logic [DIVS_W-1:0]    dsr;
   logic                 div_busy;
   logic [QUO_W-1:0]     quo;
   logic [PRED_SUM_W-1:0] pred_sum;
   logic [PRED_SUM_W-1:0] pred_sum_ff;
   logic [PRED_PROD_W-1:0] pred_prod;
   logic [15:0]          pred_quo;
   logic [31:0]          streak_inc;
   logic                 rsp_valid_ff;
   logic [15:0]          key;

   // Slot record store
   tdst_ram #(.WIDTH(REC_W), .DEPTH(MAX_TASKS)) u_ram (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (slot_ff),
      .wdata (rec_ff),
      .raddr (scan_ff),
      .rdata (ram_rdata)
   );

   // Shared divider
   tdst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .busy     (div_busy),
      .quotient (quo)
   );

   // Config register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         enable_ff <= csr_wr_data;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         id_ff  <= req_task_id;
         dl_ff  <= req_deadline;
         et_ff  <= req_exec_time;
         met_ff <= req_met;
         sl_ff  <= req_slack;
      end
   end

   // Scan index and matched slot
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.scan_clr) begin
         scan_ff <= '0;
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + SLOT_W'(1);
      end
      if (cmd.slot_cap) begin
         slot_ff <= scan_ff;
      end
   end

   // Entry valid bits; an invalid entry reads as a free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[slot_ff] <= 1'b1;
      end else if (cmd.clr_valid) begin
         valid_ff[slot_ff] <= 1'b0;
      end
   end

   assign ram_rec = slot_rec_type'(ram_rdata);
   assign eff_rec = valid_ff[scan_ff] ? ram_rec : REC_RESET;
   assign key     = (op_ff == OP_REGISTER) ? 16'd0 : id_ff;

   // Record update
   always_comb begin
      rec_in     = rec_ff;
      streak_inc = (rec_ff.streak == CNT_MAX) ? rec_ff.streak : rec_ff.streak + 32'd1;
      if (cmd.rec_cap) begin
         rec_in = eff_rec;
      end else begin
         unique case (cmd.rec_op)
            REC_HOLD: rec_in = rec_ff;
            REC_NEW: begin
               rec_in          = REC_RESET;
               rec_in.id       = id_ff;
               rec_in.deadline = dl_ff;
            end
            REC_EXEC: begin
               if (et_ff < rec_ff.best)  rec_in.best  = et_ff;
               if (et_ff > rec_ff.worst) rec_in.worst = et_ff;
               rec_in.last = et_ff;
               rec_in.runs = (rec_ff.runs == CNT_MAX) ? rec_ff.runs : rec_ff.runs + 32'd1;
            end
            REC_DEAD: begin
               if (!met_ff) begin
                  rec_in.misses = (rec_ff.misses == CNT_MAX) ? rec_ff.misses
                                                             : rec_ff.misses + 32'd1;
                  rec_in.streak = streak_inc;
                  if (streak_inc > rec_ff.peak) rec_in.peak = streak_inc;
               end else begin
                  rec_in.streak = 32'd0;
               end
               if (sl_ff < rec_ff.min_slack) rec_in.min_slack = sl_ff;
               // first slack before any run is taken as is
               if (rec_ff.runs == 32'd0) rec_in.slack_mean = sl_ff;
            end
            REC_MEAN: rec_in.mean       = quo;
            REC_AVG:  rec_in.slack_mean = quo;
            default:  rec_in = rec_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // Weighted sum for running means
   always_comb begin
      if (op_ff == OP_EXEC) begin
         mul_in = 48'(rec_ff.mean) * 48'(rec_ff.runs);
      end else begin
         mul_in = 48'(rec_ff.slack_mean) * 48'(rec_ff.runs - 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_ff <= mul_in;
         n_ff   <= rec_ff.runs;
      end
   end

   // Predicted time: weighted sum registered, then divided by 10 by reciprocal
   assign pred_sum = PRED_SUM_W'(rec_ff.mean) * PRED_SUM_W'(PRED_W_MEAN)
                   + PRED_SUM_W'(rec_ff.worst) * PRED_SUM_W'(PRED_W_WORST);

   always_ff @(posedge clock) begin
      pred_sum_ff <= pred_sum;
   end

   assign pred_prod = PRED_PROD_W'(pred_sum_ff) * PRED_PROD_W'(PRED_RECIP);
   assign pred_quo  = pred_prod[PRED_SHIFT +: 16];

   // Divider operand select
   always_comb begin
      unique case (cmd.div_src)
         DIV_EXEC: begin
            dvd = {1'b0, mul_ff} + DIVD_W'(et_ff);
            dsr = {1'b0, n_ff} + DIVS_W'(1);
         end
         DIV_SLACK: begin
            dvd = {1'b0, mul_ff} + DIVD_W'(sl_ff);
            dsr = {1'b0, n_ff};
         end
         default: begin
            dvd = '0;
            dsr = DIVS_W'(1);
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status <= cmd.rsp_status;
         if (cmd.rsp_slot) begin
            rsp_worst_time     <= rec_ff.worst;
            rsp_best_time      <= rec_ff.best;
            rsp_mean_time      <= rec_ff.mean;
            rsp_run_count      <= rec_ff.runs;
            rsp_miss_count     <= rec_ff.misses;
            rsp_miss_streak    <= rec_ff.streak;
            rsp_peak_streak    <= rec_ff.peak;
            rsp_min_slack      <= rec_ff.min_slack;
            rsp_mean_slack     <= rec_ff.slack_mean;
            rsp_predict_miss   <= (19'(rec_ff.last) * 19'd5 > 19'(rec_ff.deadline) * 19'd4)
                                  || (rec_ff.streak > STREAK_LIMIT)
                                  || (rec_ff.worst > rec_ff.deadline);
            rsp_predicted_time <= cmd.rsp_pred_div ? pred_quo : rec_ff.mean;
         end else begin
            rsp_worst_time     <= '0;
            rsp_best_time      <= '0;
            rsp_mean_time      <= '0;
            rsp_run_count      <= '0;
            rsp_miss_count     <= '0;
            rsp_miss_streak    <= '0;
            rsp_peak_streak    <= '0;
            rsp_min_slack      <= '0;
            rsp_mean_slack     <= '0;
            rsp_predict_miss   <= 1'b0;
            rsp_predicted_time <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status to controller
   assign sts.id_zero   = (id_ff == 16'd0);
   assign sts.opcode    = op_ff;
   assign sts.enable    = enable_ff;
   assign sts.match     = (eff_rec.id == key);
   assign sts.scan_last = (scan_ff == SLOT_W'(MAX_TASKS - 1));
   assign sts.runs_zero = (rec_ff.runs == 32'd0);
   assign sts.runs_gt10 = (rec_ff.runs > PRED_RUNS);
   assign sts.div_busy  = div_busy;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;
endmodule

[src/tdst_ctrl.sv]
module tdst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tdst_pkg::dp_sts_type  sts,
   output tdst_pkg::ctl_cmd_type cmd
);
   import tdst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CMP, S_DECIDE, S_DIV_GO, S_DIV_WAIT,
      S_STORE, S_PRED, S_RESP
   } state_type;

   state_type   state_ff, state_in;
   logic        found_ff, found_in;
   logic [2:0]  status_ff, status_in;
   logic        slot_ok_ff, slot_ok_in;
   logic        pred_div_ff, pred_div_in;
   div_src_type div_src_ff, div_src_in;
   logic        rec_op_gate;

   assign rec_op_gate = (sts.opcode == OP_EXEC) || (sts.opcode == OP_DEADLINE);

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      slot_ok_in  = slot_ok_ff;
      pred_div_in = pred_div_ff;
      div_src_in  = div_src_ff;
      cmd         = '0;
      cmd.rec_op  = REC_HOLD;
      cmd.div_src = div_src_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = S_RD;
            end
         end
         S_RD: begin
            pred_div_in = 1'b0;
            if (sts.id_zero) begin
               status_in  = ST_RESERVED;
               slot_ok_in = 1'b0;
               state_in   = S_RESP;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.rec_cap = 1'b1;
            if (sts.match) begin
               cmd.slot_cap = 1'b1;
               found_in     = 1'b1;
               state_in     = S_DECIDE;
            end else if (sts.scan_last) begin
               found_in = 1'b0;
               state_in = S_DECIDE;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_RD;
            end
         end
         S_DECIDE: begin
            status_in  = ST_OK;
            slot_ok_in = 1'b1;
            priority if (sts.opcode == OP_REGISTER) begin
               if (found_ff) begin
                  cmd.rec_op = REC_NEW;
                  state_in   = S_STORE;
               end else begin
                  status_in  = ST_FULL;
                  slot_ok_in = 1'b0;
                  state_in   = S_RESP;
               end
            end else if (rec_op_gate && !sts.enable) begin
               status_in  = ST_DISABLED;
               slot_ok_in = found_ff;
               state_in   = found_ff ? S_PRED : S_RESP;
            end else if (!found_ff) begin
               status_in  = ST_NOT_FOUND;
               slot_ok_in = 1'b0;
               state_in   = S_RESP;
            end else if (sts.opcode == OP_UNREGISTER) begin
               // report stays on the captured record; entry freed now
               cmd.clr_valid = 1'b1;
               state_in      = S_PRED;
            end else if (sts.opcode == OP_EXEC) begin
               cmd.rec_op = REC_EXEC;
               cmd.mul_en = 1'b1;
               div_src_in = DIV_EXEC;
               state_in   = S_DIV_GO;
            end else if (sts.opcode == OP_DEADLINE) begin
               cmd.rec_op = REC_DEAD;
               cmd.mul_en = 1'b1;
               div_src_in = DIV_SLACK;
               state_in   = sts.runs_zero ? S_STORE : S_DIV_GO;
            end else begin
               state_in = S_PRED;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!sts.div_busy) begin
               cmd.rec_op = (div_src_ff == DIV_EXEC) ? REC_MEAN : REC_AVG;
               state_in   = S_STORE;
            end
         end
         S_STORE: begin
            cmd.wr_en = 1'b1;
            state_in  = S_PRED;
         end
         S_PRED: begin
            // weighted sum is registered here, divided on the way out
            pred_div_in = sts.runs_gt10;
            state_in    = S_RESP;
         end
         S_RESP: begin
            cmd.rsp_status   = status_ff;
            cmd.rsp_slot     = slot_ok_ff;
            cmd.rsp_pred_div = pred_div_ff;
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         found_ff    <= 1'b0;
         status_ff   <= ST_OK;
         slot_ok_ff  <= 1'b0;
         pred_div_ff <= 1'b0;
         div_src_ff  <= DIV_EXEC;
      end else begin
         state_ff    <= state_in;
         found_ff    <= found_in;
         status_ff   <= status_in;
         slot_ok_ff  <= slot_ok_in;
         pred_div_ff <= pred_div_in;
         div_src_ff  <= div_src_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

[src/task_deadline_stats_table.sv]
// Channel   Ports                      Direction  Handshake
// request   req_valid/req_ready, req_*  in         valid/ready
// response  rsp_valid/rsp_ready, rsp_*  out        valid/ready
// config    csr_wr_en, csr_wr_data      in         write enable, no wait
//
// One item at a time: an accept state, then the slot search reads the record store
// once per slot, in a read state and a compare state. Execution records, and
// deadline records after the first run, add a divide and a store. Shortest for a
// reserved id, longest for an execution record in the last slot.
// Reset is synchronous; entry valid bits clear at once, no clearing pass.
// A waiting response sits in its own register; the next item's result waits for it.
module task_deadline_stats_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_task_id,
   input  logic [15:0] req_deadline,
   input  logic [15:0] req_exec_time,
   input  logic        req_met,
   input  logic [15:0] req_slack,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_worst_time,
   output logic [15:0] rsp_best_time,
   output logic [15:0] rsp_mean_time,
   output logic [31:0] rsp_run_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_miss_streak,
   output logic [31:0] rsp_peak_streak,
   output logic [15:0] rsp_min_slack,
   output logic [15:0] rsp_mean_slack,
   output logic        rsp_predict_miss,
   output logic [15:0] rsp_predicted_time
);
   import tdst_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   tdst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdst_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_task_id        (req_task_id),
      .req_deadline       (req_deadline),
      .req_exec_time      (req_exec_time),
      .req_met            (req_met),
      .req_slack          (req_slack),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_worst_time     (rsp_worst_time),
      .rsp_best_time      (rsp_best_time),
      .rsp_mean_time      (rsp_mean_time),
      .rsp_run_count      (rsp_run_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_miss_streak    (rsp_miss_streak),
      .rsp_peak_streak    (rsp_peak_streak),
      .rsp_min_slack      (rsp_min_slack),
      .rsp_mean_slack     (rsp_mean_slack),
      .rsp_predict_miss   (rsp_predict_miss),
      .rsp_predicted_time (rsp_predicted_time)
   );
endmodule
